[sv/dqs_pkg.sv]
// ----------------------------------------------------------------------------
// dqs_pkg
// Shared constants, codes and types for the integer deque with search.
// ----------------------------------------------------------------------------
`default_nettype none

package dqs_pkg;

  // storage geometry
  localparam int DEPTH       = 16;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int COUNT_OUT_W = 5;

  // request codes
  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_SEARCH     = 3'd4
  } mode_t;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EMPTY     = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_POP_DATA = 2'd1,
    ST_SEARCH   = 2'd2
  } state_t;

  // access request to the entry store
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // ring position of an offset from the head, offset at most DEPTH
  function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                 input logic [CNT_W-1:0]  off);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return ADDR_W'(sum);
  endfunction

  // ring position one step before the head
  function automatic logic [ADDR_W-1:0] wrap_dec(input logic [ADDR_W-1:0] base);
    logic [ADDR_W-1:0] res;
    if (base == '0) begin
      res = ADDR_W'(DEPTH - 1);
    end else begin
      res = base - ADDR_W'(1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[sv/dqs_store.sv]
// ----------------------------------------------------------------------------
// dqs_store
// Entry store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module dqs_store (
  input  wire logic                      clk,
  input  wire dqs_pkg::mem_req_t         req,
  output logic [dqs_pkg::DATA_W-1:0]     rdata
);

  logic [dqs_pkg::DATA_W-1:0] mem [dqs_pkg::DEPTH];
  logic [dqs_pkg::DATA_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[sv/integer_deque_with_search_unit.sv]
// ----------------------------------------------------------------------------
// integer_deque_with_search_unit
// Bounded double-ended queue of signed 32-bit numbers in a ring buffer,
// with push/pop at both ends and a front-to-back search.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result
// appears on the out_ ports for one cycle with out_valid high, and must be
// captured then, as there is no way to hold it off. Pushes, failed requests
// and unused modes give their result in the cycle after the item is taken;
// a pop that exposes a new front or back entry first reads that entry
// from the store, whose read data is registered, and gives its result
// from the ST_POP_DATA state; a search reads one stored entry per cycle
// from the front until it finds a match or has read the last live entry.
// busy falls in the cycle that carries the result, so the next item can
// be taken at the edge ending that cycle.
// The store needs no clearing after reset: only live entries are read.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_deque_with_search_unit (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic [2:0]                            in_mode,
  input  wire logic signed [31:0]                    in_value,
  output logic                                       out_valid,
  output logic [1:0]                                 out_status,
  output logic signed [31:0]                         out_front_value,
  output logic signed [31:0]                         out_back_value,
  output logic [4:0]                                 out_item_count,
  output logic                                       out_is_empty
);

  dqs_pkg::state_t                   state_r, state_nxt;
  logic [dqs_pkg::ADDR_W-1:0]        head_r, head_nxt;
  logic [dqs_pkg::CNT_W-1:0]         count_r, count_nxt;
  logic [dqs_pkg::CNT_W-1:0]         idx_r, idx_nxt;
  logic signed [dqs_pkg::DATA_W-1:0] front_r, front_nxt;
  logic signed [dqs_pkg::DATA_W-1:0] back_r, back_nxt;
  logic signed [dqs_pkg::DATA_W-1:0] value_r, value_nxt;
  logic                              pop_back_r, pop_back_nxt;
  logic                              out_valid_r, out_valid_nxt;
  dqs_pkg::status_t                  out_status_r, out_status_nxt;
  dqs_pkg::mem_req_t                 mreq;
  logic [dqs_pkg::DATA_W-1:0]        rdata;
  logic                              full;
  logic                              empty;

  // entry store
  dqs_store u_store (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );

  assign full  = (count_r == dqs_pkg::CNT_W'(dqs_pkg::DEPTH));
  assign empty = (count_r == '0);

  // state and queue registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dqs_pkg::ST_IDLE;
      head_r       <= '0;
      count_r      <= '0;
      front_r      <= '0;
      back_r       <= '0;
      out_valid_r  <= 1'b0;
      out_status_r <= dqs_pkg::STATUS_OK;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      count_r      <= count_nxt;
      front_r      <= front_nxt;
      back_r       <= back_nxt;
      out_valid_r  <= out_valid_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    value_r    <= value_nxt;
    pop_back_r <= pop_back_nxt;
  end

  // sequencer: next state, store accesses and result
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    front_nxt      = front_r;
    back_nxt       = back_r;
    value_nxt      = value_r;
    pop_back_nxt   = pop_back_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    mreq           = '0;

    unique case (state_r)
      dqs_pkg::ST_IDLE: begin
        if (start) begin
          value_nxt      = in_value;
          out_status_nxt = dqs_pkg::STATUS_OK;
          unique case (in_mode)
            dqs_pkg::MODE_PUSH_FRONT: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_status_nxt = dqs_pkg::STATUS_FULL;
              end else begin
                head_nxt   = dqs_pkg::wrap_dec(head_r);
                mreq.we    = 1'b1;
                mreq.waddr = dqs_pkg::wrap_dec(head_r);
                mreq.wdata = in_value;
                count_nxt  = count_r + dqs_pkg::CNT_W'(1);
                front_nxt  = in_value;
                if (empty) begin
                  back_nxt = in_value;
                end
              end
            end
            dqs_pkg::MODE_PUSH_BACK: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_status_nxt = dqs_pkg::STATUS_FULL;
              end else begin
                mreq.we    = 1'b1;
                mreq.waddr = dqs_pkg::wrap_add(head_r, count_r);
                mreq.wdata = in_value;
                count_nxt  = count_r + dqs_pkg::CNT_W'(1);
                back_nxt   = in_value;
                if (empty) begin
                  front_nxt = in_value;
                end
              end
            end
            dqs_pkg::MODE_POP_FRONT: begin
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = dqs_pkg::STATUS_EMPTY;
              end else begin
                head_nxt  = dqs_pkg::wrap_add(head_r, dqs_pkg::CNT_W'(1));
                count_nxt = count_r - dqs_pkg::CNT_W'(1);
                if (count_r == dqs_pkg::CNT_W'(1)) begin
                  // only entry removed
                  out_valid_nxt = 1'b1;
                  front_nxt     = '0;
                  back_nxt      = '0;
                end else begin
                  // fetch the new front entry
                  mreq.re      = 1'b1;
                  mreq.raddr   = dqs_pkg::wrap_add(head_r, dqs_pkg::CNT_W'(1));
                  pop_back_nxt = 1'b0;
                  state_nxt    = dqs_pkg::ST_POP_DATA;
                end
              end
            end
            dqs_pkg::MODE_POP_BACK: begin
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = dqs_pkg::STATUS_EMPTY;
              end else begin
                count_nxt = count_r - dqs_pkg::CNT_W'(1);
                if (count_r == dqs_pkg::CNT_W'(1)) begin
                  out_valid_nxt = 1'b1;
                  front_nxt     = '0;
                  back_nxt      = '0;
                end else begin
                  // fetch the new back entry
                  mreq.re      = 1'b1;
                  mreq.raddr   = dqs_pkg::wrap_add(head_r, count_r - dqs_pkg::CNT_W'(2));
                  pop_back_nxt = 1'b1;
                  state_nxt    = dqs_pkg::ST_POP_DATA;
                end
              end
            end
            dqs_pkg::MODE_SEARCH: begin
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = dqs_pkg::STATUS_NOT_FOUND;
              end else begin
                // start the scan at the front entry
                mreq.re    = 1'b1;
                mreq.raddr = head_r;
                idx_nxt    = dqs_pkg::CNT_W'(1);
                state_nxt  = dqs_pkg::ST_SEARCH;
              end
            end
            default: begin
              // unused code: snapshot only
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      dqs_pkg::ST_POP_DATA: begin
        if (pop_back_r) begin
          back_nxt = rdata;
        end else begin
          front_nxt = rdata;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = dqs_pkg::ST_IDLE;
      end

      dqs_pkg::ST_SEARCH: begin
        // rdata holds the entry at offset idx_r - 1
        if (rdata == value_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = dqs_pkg::STATUS_OK;
          state_nxt      = dqs_pkg::ST_IDLE;
        end else if (idx_r == count_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = dqs_pkg::STATUS_NOT_FOUND;
          state_nxt      = dqs_pkg::ST_IDLE;
        end else begin
          mreq.re    = 1'b1;
          mreq.raddr = dqs_pkg::wrap_add(head_r, idx_r);
          idx_nxt    = idx_r + dqs_pkg::CNT_W'(1);
        end
      end

      default: begin
        state_nxt = dqs_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  assign busy            = (state_r != dqs_pkg::ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_front_value = front_r;
  assign out_back_value  = back_r;
  assign out_item_count  = dqs_pkg::COUNT_OUT_W'(count_r);
  assign out_is_empty    = empty;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= dqs_pkg::CNT_W'(dqs_pkg::DEPTH))
    else $error("entry count above depth");

  a_search_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == dqs_pkg::ST_SEARCH |-> (idx_r != '0 && idx_r <= count_r))
    else $error("search index outside live entries");

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == dqs_pkg::ST_IDLE)
    else $error("result strobe while still working");

  a_item_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && state_r == dqs_pkg::ST_IDLE) |=> (out_valid_r || state_r != dqs_pkg::ST_IDLE))
    else $error("accepted item neither answered nor in progress");

  a_empty_snapshot: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> (front_r == '0 && back_r == '0))
    else $error("empty queue shows a non-zero end value");

endmodule

`default_nettype wire

[test/deque_scoreboard_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deque_scoreboard_pkg
// Ring-buffer deque predictor that works out the status and snapshot for each
// accepted item, and checks the unit's results against them in order.
// ----------------------------------------------------------------------------
package deque_scoreboard_pkg;
  import dqs_pkg::*;

  // one predicted result: status and the queue seen after the item
  typedef struct {
    status_t            status;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic [4:0]         item_count;
    logic               is_empty;
  } deque_view_t;

  class deque_scoreboard;
    logic signed [31:0] ring [DEPTH];
    int unsigned        head;
    int unsigned        fill;
    deque_view_t        awaited [$];
    int                 errors;

    function new();
      head   = 0;
      fill   = 0;
      errors = 0;
      foreach (ring[i]) ring[i] = '0;
    endfunction

    // ring slot of an offset from the front
    function int unsigned slot_of(int unsigned offset);
      return (head + offset) % DEPTH;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // a live number, so that searches often hit
    function logic signed [31:0] pick_live();
      logic signed [31:0] n;
      if (fill == 0) begin
        n = $urandom;
      end else begin
        n = ring[slot_of($urandom_range(fill - 1, 0))];
      end
      return n;
    endfunction

    // apply one accepted item and queue the result it should give
    function void note_request(logic [2:0] mode, logic signed [31:0] value);
      deque_view_t v;
      status_t     st;
      st = STATUS_OK;
      case (mode)
        MODE_PUSH_FRONT: begin
          if (fill >= DEPTH) begin
            st = STATUS_FULL;
          end else begin
            head = (head + DEPTH - 1) % DEPTH;
            ring[head] = value;
            fill++;
          end
        end
        MODE_PUSH_BACK: begin
          if (fill >= DEPTH) begin
            st = STATUS_FULL;
          end else begin
            ring[slot_of(fill)] = value;
            fill++;
          end
        end
        MODE_POP_FRONT: begin
          if (fill == 0) begin
            st = STATUS_EMPTY;
          end else begin
            head = (head + 1) % DEPTH;
            fill--;
          end
        end
        MODE_POP_BACK: begin
          if (fill == 0) begin
            st = STATUS_EMPTY;
          end else begin
            fill--;
          end
        end
        MODE_SEARCH: begin
          st = STATUS_NOT_FOUND;
          for (int i = 0; i < fill; i++) begin
            if (ring[slot_of(i)] == value) begin
              st = STATUS_OK;
            end
          end
        end
        default: ;
      endcase
      v.status     = st;
      v.item_count = 5'(fill);
      v.is_empty   = (fill == 0);
      if (fill == 0) begin
        v.front_value = '0;
        v.back_value  = '0;
      end else begin
        v.front_value = ring[slot_of(0)];
        v.back_value  = ring[slot_of(fill - 1)];
      end
      awaited.push_back(v);
    endfunction

    // compare one result, field by field, with the oldest prediction
    function void check_result(logic [1:0] status, logic signed [31:0] front_value,
                               logic signed [31:0] back_value, logic [4:0] item_count,
                               logic is_empty);
      deque_view_t v;
      if (awaited.size() == 0) begin
        $display("%0t: result with nothing expected, status %0d count %0d",
                 $time, status, item_count);
        errors++;
        return;
      end
      v = awaited.pop_front();
      if (status !== v.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d",
                 $time, v.status, status);
        errors++;
      end
      if (front_value !== v.front_value) begin
        $display("%0t: front value mismatch, expected %0d, actual %0d",
                 $time, v.front_value, front_value);
        errors++;
      end
      if (back_value !== v.back_value) begin
        $display("%0t: back value mismatch, expected %0d, actual %0d",
                 $time, v.back_value, back_value);
        errors++;
      end
      if (item_count !== v.item_count) begin
        $display("%0t: count mismatch, expected %0d, actual %0d",
                 $time, v.item_count, item_count);
        errors++;
      end
      if (is_empty !== v.is_empty) begin
        $display("%0t: empty flag mismatch, expected %0d, actual %0d",
                 $time, v.is_empty, is_empty);
        errors++;
      end
    endfunction
  endclass

endpackage

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Pushes, pops and searches on the deque unit in random bursts, first a short
// directed run over empty, extremes and unused modes, then biased phases that
// fill and drain the ring; every result is checked against a predictor.
// ----------------------------------------------------------------------------
module testbench;
  import dqs_pkg::*;
  import deque_scoreboard_pkg::*;

  localparam int RANDOM_ITEMS = 1400;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 24;

  localparam logic signed [31:0] MOST_NEGATIVE = 32'sh8000_0000;
  localparam logic signed [31:0] MOST_POSITIVE = 32'sh7fff_ffff;

  logic               clk      = 1'b0;
  logic               rst_n    = 1'b0;
  logic               start    = 1'b0;
  logic [2:0]         in_mode  = '0;
  logic signed [31:0] in_value = '0;
  logic               busy;
  logic               out_valid;
  logic [1:0]         out_status;
  logic signed [31:0] out_front_value;
  logic signed [31:0] out_back_value;
  logic [4:0]         out_item_count;
  logic               out_is_empty;

  deque_scoreboard board;
  int              quiet_cycles = 0;

  integer_deque_with_search_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value),
    .out_item_count  (out_item_count),
    .out_is_empty    (out_is_empty)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predict each accepted item
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      board.note_request(in_mode, in_value);
    end
  end

  // check each result in its strobe cycle
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      board.check_result(out_status, out_front_value, out_back_value,
                         out_item_count, out_is_empty);
    end
  end

  // watchdog on cycles with no handshake of either kind
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no item or result for %0d cycles", $time, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one item and hold it until taken
  task automatic send_item(input logic [2:0] mode, input logic signed [31:0] value);
    in_mode  <= mode;
    in_value <= value;
    start    <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // hold off until every predicted result has been seen
  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  // small values give duplicates, extremes test the full range
  function automatic logic signed [31:0] pick_number();
    logic signed [31:0] n;
    int unsigned        roll;
    roll = $urandom_range(9, 0);
    if (roll < 3) begin
      n = $urandom_range(6, 0);
      n = n - 32'sd3;
    end else if (roll == 3) begin
      n = MOST_NEGATIVE;
    end else if (roll == 4) begin
      n = MOST_POSITIVE;
    end else begin
      n = $urandom;
    end
    return n;
  endfunction

  // request mix for the current phase, with a few unused modes
  function automatic logic [2:0] pick_mode(input int push_pct, input int pop_pct);
    int unsigned roll;
    logic [2:0]  m;
    roll = $urandom_range(99, 0);
    if (roll < 3) begin
      m = 3'($urandom_range(7, 5));
    end else if (roll < 3 + push_pct) begin
      m = $urandom_range(1, 0) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
    end else if (roll < 3 + push_pct + pop_pct) begin
      m = $urandom_range(1, 0) ? MODE_POP_FRONT : MODE_POP_BACK;
    end else begin
      m = MODE_SEARCH;
    end
    return m;
  endfunction

  initial begin
    int                 sent;
    int                 burst;
    int                 phase_left;
    int                 push_pct;
    int                 pop_pct;
    logic [2:0]         mode;
    logic signed [31:0] value;
    board = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue: failed search and pops, unused mode leaves it alone
    send_item(MODE_SEARCH, 32'sd0);
    send_item(MODE_POP_FRONT, 32'sd0);
    send_item(MODE_POP_BACK, -32'sd1);
    send_item(3'd5, 32'sd7);
    // extremes at both ends; found at front, found at back, not found
    send_item(MODE_PUSH_FRONT, MOST_NEGATIVE);
    send_item(MODE_PUSH_BACK, MOST_POSITIVE);
    send_item(MODE_SEARCH, MOST_NEGATIVE);
    send_item(MODE_SEARCH, MOST_POSITIVE);
    send_item(MODE_SEARCH, 32'sd0);
    send_item(3'd6, MOST_POSITIVE);
    send_item(3'd7, MOST_NEGATIVE);
    // front pop leaves one entry, back pop removes the last one
    send_item(MODE_POP_FRONT, 32'sd0);
    send_item(MODE_POP_BACK, 32'sd0);
    wait_for_results();

    // random phases, the first one filling past full
    sent       = 0;
    phase_left = 24;
    push_pct   = 96;
    pop_pct    = 0;
    burst      = $urandom_range(8, 1);
    while (sent < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(60, 10);
        case ($urandom_range(3, 0))
          0: begin
            push_pct = 75;
            pop_pct  = 10;
          end
          1: begin
            push_pct = 10;
            pop_pct  = 75;
          end
          2: begin
            push_pct = 35;
            pop_pct  = 35;
          end
          default: begin
            push_pct = 20;
            pop_pct  = 20;
          end
        endcase
      end
      mode = pick_mode(push_pct, pop_pct);
      if (mode == MODE_SEARCH && $urandom_range(9, 0) < 6) begin
        value = board.pick_live();
      end else begin
        value = pick_number();
      end
      send_item(mode, value);
      sent++;
      phase_left--;
      burst--;
      // gap after each burst; now and then let the unit drain completely
      if (burst == 0) begin
        if ($urandom_range(19, 0) == 0) begin
          wait_for_results();
        end else begin
          pause_sender($urandom_range(20, 1));
        end
        burst = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
      end
    end

    // let the last results arrive, then watch for strays
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
sv/dqs_pkg.sv
sv/dqs_store.sv
sv/integer_deque_with_search_unit.sv
test/deque_scoreboard_pkg.sv
test/testbench.sv
